### rtl/worst_fit_block_allocator_core_defines.svh
// Assertion macros for the worst-fit allocator.
`ifndef WORST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define WORST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define WFA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define WFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define WFA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define WFA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/wfa_pkg.sv
`default_nettype none
package wfa_pkg;
	localparam int MaxBlocks = 64;
	localparam int PageBytes = 4096;
	localparam int IdxW = $clog2(MaxBlocks);
	localparam int CntW = $clog2(MaxBlocks + 1);
	localparam int AddrW = 21;
	localparam logic [AddrW-1:0] HeaderBytes = 21'd32;
	localparam logic [AddrW-1:0] FirstBlock = 21'd24;
	localparam logic [AddrW-1:0] RegionLimit = 21'd1048576;
	localparam int PageSh = $clog2(PageBytes);
	localparam logic [1:0] StOk = 2'd0;
	localparam logic [1:0] StNoSpace = 2'd1;
	localparam logic [1:0] StBadPtr = 2'd2;

	typedef struct packed {
		logic [AddrW-1:0] start;
		logic [AddrW-1:0] length;
		logic in_use;
	} entry_t;

	// Table access command from the sequencer.
	typedef struct packed {
		logic we;
		logic [IdxW-1:0] waddr;
		entry_t wdata;
		logic [IdxW-1:0] raddr;
	} tbl_cmd_t;
endpackage
`default_nettype wire

### rtl/wfa_table.sv
`default_nettype none
// Block table: one write port and one registered read port.
module wfa_table (
	input wire logic clk,
	input wire wfa_pkg::tbl_cmd_t cmd,
	output wfa_pkg::entry_t rdata
);
	wfa_pkg::entry_t mem [wfa_pkg::MaxBlocks];

	// Read first (a same-address write returns the old data), registered read.
	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem[cmd.waddr] <= cmd.wdata;
		end
		rdata <= mem[cmd.raddr];
	end
endmodule
`default_nettype wire

### rtl/worst_fit_block_allocator_core.sv
`default_nettype none
// Channel   Direction  Payload
// s_axis    in         tuser: mode; tdata: request_size, block_offset, offset_present, merge_flag
// m_axis    out        tdata: status, payload_offset
// cfg       in         region_bytes, write enable only
// An allocate scans the table and, on a split, shifts the entries above the chosen one;
// the table holds up to 64 blocks; the scan and the shift each walk it one entry a cycle.
// A free with merge runs a lookup pass if an offset is given, then a compaction pass.
// Region writes hold off requests during setup. Reset clears the block count at once.
// A finished result waits in the output register; the next request is taken
// once it has been delivered.
`include "worst_fit_block_allocator_core_defines.svh"
module worst_fit_block_allocator_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// [0] mode
	input wire logic s_axis_tuser,
	// [20:0] request_size, [41:21] block_offset,
	// [42] offset_present, [43] merge_flag, [47:44] zero
	input wire logic [47:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// [1:0] status, [22:2] payload_offset, [23] zero
	output logic [23:0] m_axis_tdata,
	input wire logic cfg_we,
	input wire logic [20:0] cfg_wdata
);
	localparam int IW = wfa_pkg::IdxW;
	localparam int CW = wfa_pkg::CntW;
	localparam int AW = wfa_pkg::AddrW;
	localparam int NW = AW + 1;
	localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_DECIDE = 4'd2,
		S_SHIFT = 4'd3, S_SPLIT = 4'd4, S_FIND = 4'd5, S_MERGE = 4'd6,
		S_DONE = 4'd7, S_TAKE = 4'd8;

	logic [3:0] state_q;
	logic [CW-1:0] count_q, rd_q, wr_q;
	logic rd_valid_q;
	logic [AW-1:0] total_q, offset_q, best_len_q;
	logic [NW-1:0] need_q;
	logic [IW-1:0] best_q;
	logic found_q, present_q, merge_q, mode_q, inited_q;
	wfa_pkg::entry_t best_ent_q, acc_q;
	logic acc_valid_q;
	logic [1:0] status_q;
	logic [AW-1:0] payload_q;
	wfa_pkg::tbl_cmd_t cmd;
	wfa_pkg::entry_t rdata;
	logic [AW-1:0] cap, total_c, sub_a, sub_b, diff;

	wfa_table u_table (.clk(clk), .cmd(cmd), .rdata(rdata));

	assign s_axis_tready = (state_q == S_IDLE) && !m_axis_tvalid;
	assign m_axis_tdata = {1'b0, payload_q, status_q};

	// Region size, capped at the region limit and rounded up to a page.
	always_comb begin
		cap = (cfg_wdata > wfa_pkg::RegionLimit) ? wfa_pkg::RegionLimit : cfg_wdata;
		total_c = (((cap + AW'(wfa_pkg::PageBytes - 1)) >> wfa_pkg::PageSh)
			<< wfa_pkg::PageSh);
	end

	// The shared subtractor.
	always_comb begin
		sub_a = best_len_q;
		sub_b = need_q[AW-1:0];
		if (state_q == S_FIND) begin
			sub_a = offset_q;
			sub_b = wfa_pkg::HeaderBytes;
		end
		diff = sub_a - sub_b;
	end

	// Table command.
	always_comb begin
		cmd = '0;
		cmd.raddr = rd_q[IW-1:0];
		case (state_q)
			S_SHIFT: begin
				// Moving down from the top: read i-1 arrives, write it to i.
				cmd.raddr = rd_q[IW-1:0];
				cmd.we = rd_valid_q;
				cmd.waddr = wr_q[IW-1:0];
				cmd.wdata = rdata;
			end
			S_SPLIT: begin
				cmd.we = 1'b1;
				cmd.waddr = best_q + IW'(1);
				cmd.wdata.start = best_ent_q.start + need_q[AW-1:0];
				cmd.wdata.length = diff;
				cmd.wdata.in_use = 1'b0;
			end
			S_TAKE: begin
				// A region build writes a free block; an allocate marks it used.
				cmd.we = 1'b1;
				cmd.waddr = best_q;
				cmd.wdata = best_ent_q;
				cmd.wdata.in_use = !mode_q;
				if ({1'b0, best_len_q} != need_q) cmd.wdata.length = need_q[AW-1:0];
			end
			S_FIND: begin
				cmd.we = rd_valid_q && present_q && !found_q &&
					(rdata.start == diff);
				cmd.waddr = wr_q[IW-1:0];
				cmd.wdata = rdata;
				cmd.wdata.in_use = 1'b0;
			end
			S_MERGE: begin
				cmd.we = rd_valid_q && acc_valid_q &&
					!(!acc_q.in_use && !rdata.in_use);
				cmd.waddr = wr_q[IW-1:0];
				cmd.wdata = acc_q;
			end
			S_DONE: begin
				cmd.we = merge_q && acc_valid_q;
				cmd.waddr = wr_q[IW-1:0];
				cmd.wdata = acc_q;
			end
			default: begin
				cmd.raddr = rd_q[IW-1:0];
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			inited_q <= 1'b0;
			total_q <= '0;
			m_axis_tvalid <= 1'b0;
			rd_valid_q <= 1'b0;
			rd_q <= '0;
			wr_q <= '0;
			found_q <= 1'b0;
			acc_valid_q <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cfg_we) begin
						inited_q <= (cfg_wdata != '0);
						total_q <= total_c;
						count_q <= '0;
						if (cfg_wdata != '0 && total_c > wfa_pkg::FirstBlock) begin
							state_q <= S_TAKE;
							mode_q <= 1'b1;
							best_q <= '0;
							best_ent_q.start <= wfa_pkg::FirstBlock;
							best_ent_q.length <= total_c - wfa_pkg::FirstBlock;
							best_len_q <= '0;
							need_q <= '0;
						end
					end else if (s_axis_tvalid && s_axis_tready) begin
						mode_q <= s_axis_tuser;
						need_q <= (({1'b0, s_axis_tdata[20:0]} + NW'(7)) & ~NW'(7)) +
							{1'b0, wfa_pkg::HeaderBytes};
						offset_q <= s_axis_tdata[41:21];
						present_q <= s_axis_tdata[42];
						merge_q <= s_axis_tdata[43];
						rd_q <= '0;
						wr_q <= '0;
						rd_valid_q <= 1'b0;
						found_q <= 1'b0;
						best_len_q <= '0;
						acc_valid_q <= 1'b0;
						payload_q <= '0;
						if (!inited_q) begin
							status_q <= wfa_pkg::StNoSpace;
							m_axis_tvalid <= 1'b1;
						end else if (!s_axis_tuser) begin
							state_q <= S_SCAN;
						end else if (!s_axis_tdata[42] && !s_axis_tdata[43]) begin
							status_q <= wfa_pkg::StBadPtr;
							m_axis_tvalid <= 1'b1;
						end else if (s_axis_tdata[42] &&
							(s_axis_tdata[41:21] > total_q ||
							s_axis_tdata[41:21] < wfa_pkg::HeaderBytes)) begin
							status_q <= wfa_pkg::StBadPtr;
							m_axis_tvalid <= 1'b1;
						end else begin
							state_q <= S_FIND;
						end
					end
				end
				S_SCAN: begin
					// One entry a cycle through the read port.
					if (rd_valid_q && !rdata.in_use && rdata.length > best_len_q) begin
						best_len_q <= rdata.length;
						best_q <= wr_q[IW-1:0];
						best_ent_q <= rdata;
						found_q <= 1'b1;
					end
					if (rd_valid_q) wr_q <= wr_q + CW'(1);
					if (rd_q < count_q) begin
						rd_q <= rd_q + CW'(1);
						rd_valid_q <= 1'b1;
					end else begin
						rd_valid_q <= 1'b0;
						if (!rd_valid_q) state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (!found_q || {1'b0, best_len_q} < need_q) begin
						status_q <= wfa_pkg::StNoSpace;
						m_axis_tvalid <= 1'b1;
						state_q <= S_IDLE;
					end else if ({1'b0, best_len_q} == need_q) begin
						state_q <= S_TAKE;
					end else if (diff <= wfa_pkg::HeaderBytes ||
						count_q >= CW'(wfa_pkg::MaxBlocks)) begin
						status_q <= wfa_pkg::StNoSpace;
						m_axis_tvalid <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SHIFT;
						rd_q <= count_q - CW'(1);
						wr_q <= count_q;
						rd_valid_q <= 1'b0;
					end
				end
				S_SHIFT: begin
					// Entry i-1 moves up to i, from the top down to best+2.
					if (rd_valid_q) wr_q <= wr_q - CW'(1);
					if (rd_q > CW'(best_q) && !(rd_valid_q && wr_q == CW'(best_q) + CW'(2)))
					begin
						rd_q <= rd_q - CW'(1);
						rd_valid_q <= (wr_q > CW'(best_q) + CW'(1));
						if (!rd_valid_q && wr_q <= CW'(best_q) + CW'(1)) begin
							state_q <= S_SPLIT;
						end
					end else begin
						rd_valid_q <= 1'b0;
						if (!rd_valid_q || wr_q == CW'(best_q) + CW'(2)) state_q <= S_SPLIT;
					end
				end
				S_SPLIT: begin
					count_q <= count_q + CW'(1);
					state_q <= S_TAKE;
				end
				S_TAKE: begin
					if (mode_q) begin
						// Region build: lone free block.
						count_q <= CW'(1);
						state_q <= S_IDLE;
					end else begin
						status_q <= wfa_pkg::StOk;
						payload_q <= best_ent_q.start + wfa_pkg::HeaderBytes;
						m_axis_tvalid <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_FIND: begin
					if (present_q && rd_valid_q && !found_q && rdata.start == diff) begin
						found_q <= 1'b1;
					end
					if (rd_valid_q) wr_q <= wr_q + CW'(1);
					if (rd_q < count_q && present_q) begin
						rd_q <= rd_q + CW'(1);
						rd_valid_q <= 1'b1;
					end else if (rd_valid_q) begin
						rd_valid_q <= 1'b0;
					end else begin
						if (present_q && !found_q) begin
							status_q <= wfa_pkg::StBadPtr;
							m_axis_tvalid <= 1'b1;
							state_q <= S_IDLE;
						end else if (merge_q) begin
							state_q <= S_MERGE;
							rd_q <= '0;
							wr_q <= '0;
						end else begin
							status_q <= wfa_pkg::StOk;
							m_axis_tvalid <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_MERGE: begin
					// Compaction: acc holds the entry being built at wr.
					if (rd_valid_q) begin
						if (acc_valid_q && !acc_q.in_use && !rdata.in_use) begin
							acc_q.length <= acc_q.length + rdata.length;
						end else begin
							if (acc_valid_q) wr_q <= wr_q + CW'(1);
							acc_q <= rdata;
							acc_valid_q <= 1'b1;
						end
					end
					if (rd_q < count_q) begin
						rd_q <= rd_q + CW'(1);
						rd_valid_q <= 1'b1;
					end else begin
						rd_valid_q <= 1'b0;
						if (!rd_valid_q) state_q <= S_DONE;
					end
				end
				S_DONE: begin
					count_q <= acc_valid_q ? wr_q + CW'(1) : '0;
					status_q <= wfa_pkg::StOk;
					payload_q <= '0;
					m_axis_tvalid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Checks.
	`WFA_ASSERT_IMPL(a_count_max, clk, arst_n, 1'b1, count_q <= CW'(wfa_pkg::MaxBlocks))
	`WFA_ASSERT_IMPL(a_busy_not_ready, clk, arst_n, state_q != S_IDLE, !s_axis_tready)
	`WFA_ASSERT_IMPL(a_err_zero, clk, arst_n, m_axis_tvalid && status_q != wfa_pkg::StOk,
		payload_q == '0)
	`WFA_ASSERT_NEXT(a_split_grows, clk, arst_n, state_q == S_SPLIT,
		count_q == $past(count_q) + CW'(1))
endmodule
`default_nettype wire

### tb/wfa_scoreboard.sv
`timescale 1ns / 100ps
`default_nettype none
module wfa_scoreboard (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	input wire logic s_axis_tready,
	input wire logic s_axis_tuser,
	input wire logic [47:0] s_axis_tdata,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic [23:0] m_axis_tdata,
	input wire logic cfg_we,
	input wire logic [20:0] cfg_wdata,
	output int fail_count,
	output int pending_count,
	output int result_count
);
	typedef struct packed {
		logic [1:0] status;
		logic [wfa_pkg::AddrW-1:0] payload;
	} alloc_result_t;

	// Shadow copy of the block table.
	logic [wfa_pkg::AddrW-1:0] blk_start [wfa_pkg::MaxBlocks];
	logic [wfa_pkg::AddrW-1:0] blk_len [wfa_pkg::MaxBlocks];
	logic blk_used [wfa_pkg::MaxBlocks];
	int blk_count;
	int unsigned region_req;
	int unsigned region_total;
	alloc_result_t expected_results[$];

	// Rebuild the region from a register value.
	function automatic void rebuild_region(input logic [20:0] value);
		int unsigned r;
		r = value;
		region_req = r;
		blk_count = 0;
		region_total = 0;
		if (r != 0) begin
			if (r > wfa_pkg::RegionLimit) r = wfa_pkg::RegionLimit;
			region_total = ((r + wfa_pkg::PageBytes - 1) / wfa_pkg::PageBytes) *
				wfa_pkg::PageBytes;
			if (region_total > wfa_pkg::FirstBlock) begin
				blk_start[0] = wfa_pkg::FirstBlock;
				blk_len[0] = region_total - wfa_pkg::FirstBlock;
				blk_used[0] = 1'b0;
				blk_count = 1;
			end
		end
	endfunction

	// Collapse each run of adjacent free blocks into one.
	function automatic void coalesce_free();
		int w;
		w = 0;
		for (int i = 0; i < blk_count; i++) begin
			if (w > 0 && !blk_used[w-1] && !blk_used[i]) begin
				blk_len[w-1] = blk_len[w-1] + blk_len[i];
			end else begin
				blk_start[w] = blk_start[i];
				blk_len[w] = blk_len[i];
				blk_used[w] = blk_used[i];
				w++;
			end
		end
		blk_count = w;
	endfunction

	function automatic alloc_result_t allocate_worst_fit(input int unsigned size);
		alloc_result_t res;
		int unsigned need, best_len, rem;
		int best;
		bit found;
		res = '0;
		need = ((size + 7) / 8) * 8 + wfa_pkg::HeaderBytes;
		best = 0;
		best_len = 0;
		found = 0;
		for (int i = 0; i < blk_count; i++) begin
			if (!blk_used[i] && blk_len[i] > best_len) begin
				best_len = blk_len[i];
				best = i;
				found = 1;
			end
		end
		if (!found || best_len < need) begin
			res.status = wfa_pkg::StNoSpace;
			return res;
		end
		if (best_len == need) begin
			blk_used[best] = 1'b1;
			res.payload = blk_start[best] + wfa_pkg::HeaderBytes;
			return res;
		end
		rem = best_len - need;
		if (rem <= wfa_pkg::HeaderBytes || blk_count >= wfa_pkg::MaxBlocks) begin
			res.status = wfa_pkg::StNoSpace;
			return res;
		end
		for (int i = blk_count; i > best + 1; i--) begin
			blk_start[i] = blk_start[i-1];
			blk_len[i] = blk_len[i-1];
			blk_used[i] = blk_used[i-1];
		end
		blk_start[best+1] = blk_start[best] + need;
		blk_len[best+1] = rem;
		blk_used[best+1] = 1'b0;
		blk_len[best] = need;
		blk_used[best] = 1'b1;
		blk_count++;
		res.payload = blk_start[best] + wfa_pkg::HeaderBytes;
		return res;
	endfunction

	function automatic logic [1:0] release_block(input int unsigned offset, input bit present,
		input bit merge);
		bit hit;
		hit = 0;
		if (!present && !merge) return wfa_pkg::StBadPtr;
		if (present) begin
			if (offset > region_total || offset < wfa_pkg::HeaderBytes)
				return wfa_pkg::StBadPtr;
			for (int i = 0; i < blk_count; i++) begin
				if (blk_start[i] == offset - wfa_pkg::HeaderBytes) begin
					blk_used[i] = 1'b0;
					hit = 1;
					break;
				end
			end
			if (!hit) return wfa_pkg::StBadPtr;
		end
		if (merge) coalesce_free();
		return wfa_pkg::StOk;
	endfunction

	function automatic alloc_result_t serve_request(input logic mode, input logic [47:0] req);
		alloc_result_t res;
		res = '0;
		if (region_req == 0) res.status = wfa_pkg::StNoSpace;
		else if (mode == 1'b0) res = allocate_worst_fit(req[20:0]);
		else res.status = release_block(req[41:21], req[42], req[43]);
		if (res.status != wfa_pkg::StOk) res.payload = '0;
		return res;
	endfunction

	// Predict on accepted requests, compare on delivered results.
	always @(posedge clk or negedge arst_n) begin
		alloc_result_t exp_res;
		alloc_result_t act_res;
		int errs;
		if (!arst_n) begin
			fail_count <= 0;
			result_count <= 0;
			pending_count <= 0;
			expected_results.delete();
			rebuild_region('0);
		end else begin
			errs = 0;
			if (cfg_we) rebuild_region(cfg_wdata);
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(serve_request(s_axis_tuser, s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				act_res.status = m_axis_tdata[1:0];
				act_res.payload = m_axis_tdata[22:2];
				result_count <= result_count + 1;
				if (expected_results.size() == 0) begin
					$error("unexpected result: status %0d payload_offset %0d",
						act_res.status, act_res.payload);
					errs++;
				end else begin
					exp_res = expected_results.pop_front();
					if (exp_res.status !== act_res.status) begin
						$error("status: expected %0d, got %0d", exp_res.status,
							act_res.status);
						errs++;
					end
					if (exp_res.payload !== act_res.payload) begin
						$error("payload_offset: expected %0d, got %0d", exp_res.payload,
							act_res.payload);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
			pending_count <= expected_results.size();
		end
	end
endmodule
`default_nettype wire

### tb/tb_worst_fit_block_allocator_core.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_worst_fit_block_allocator_core;
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE = 1'b1;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 300;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	// [0] mode
	logic s_axis_tuser;
	// [20:0] request_size, [41:21] block_offset,
	// [42] offset_present, [43] merge_flag, [47:44] zero
	logic [47:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	// [1:0] status, [22:2] payload_offset, [23] zero
	logic [23:0] m_axis_tdata;
	logic cfg_we;
	logic [20:0] cfg_wdata;
	int fail_count;
	int pending_count;
	int result_count;
	int cycle_count;
	int request_count;
	bit long_hold;
	int live_offsets[$];

	worst_fit_block_allocator_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	wfa_scoreboard checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .pending_count(pending_count),
		.result_count(result_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Track payload offsets handed out so frees can target live blocks.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready && m_axis_tdata[1:0] == wfa_pkg::StOk
			&& m_axis_tdata[22:2] != 0)
			live_offsets.push_back(m_axis_tdata[22:2]);
	end

	// Receiver side: random stalls, plus one long hold-off on demand.
	initial begin
		int g;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				m_axis_tready <= 1'b0;
				repeat (400) @(negedge clk);
				long_hold = 0;
			end
			g = gap_len();
			if (g > 0) begin
				m_axis_tready <= 1'b0;
				repeat (g) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	// The valid line stays up between back-to-back requests and drops in gaps.
	task automatic send_request(input logic mode, input int unsigned size,
		input int unsigned offset, input bit present, input bit merge);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		s_axis_tuser <= mode;
		s_axis_tdata <= {4'b0000, merge, present, offset[20:0], size[20:0]};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
		request_count++;
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_region(input logic [20:0] value);
		wait_idle();
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		live_offsets.delete();
	endtask

	task automatic random_request();
		int r;
		int idx;
		int unsigned off;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			if ($urandom_range(0, 19) == 0) send_request(MODE_ALLOC, $urandom, 0, 0, 0);
			else send_request(MODE_ALLOC, $urandom_range(0, 600), $urandom, $urandom, $urandom);
		end else if (r < 85 && live_offsets.size() > 0) begin
			idx = $urandom_range(0, live_offsets.size() - 1);
			off = live_offsets[idx];
			live_offsets.delete(idx);
			send_request(MODE_FREE, $urandom, off, 1, $urandom_range(0, 2) == 0);
		end else begin
			send_request(MODE_FREE, $urandom, $urandom, $urandom, $urandom);
		end
	endtask

	initial begin
		logic [20:0] cfg_vals[6];
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		cycle_count = 0;
		request_count = 0;
		long_hold = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Uninitialized region: every request fails with no space.
		send_request(MODE_ALLOC, 8, 0, 0, 0);
		send_request(MODE_FREE, 0, 56, 1, 1);

		// Tiny region rounds up to one page; then the register above its range.
		write_region(21'd1);
		send_request(MODE_ALLOC, 0, 0, 0, 0);
		send_request(MODE_ALLOC, 4096, 0, 0, 0);
		send_request(MODE_ALLOC, 21'h1FFFFF, 0, 0, 0);
		send_request(MODE_ALLOC, 4000, 0, 0, 0);
		send_request(MODE_ALLOC, 1, 0, 0, 0);
		send_request(MODE_FREE, 0, 0, 0, 0);
		send_request(MODE_FREE, 0, 0, 0, 1);
		send_request(MODE_FREE, 0, 8, 1, 0);
		send_request(MODE_FREE, 0, 4097, 1, 0);
		send_request(MODE_FREE, 0, 21'h1FFFFF, 1, 1);
		send_request(MODE_FREE, 0, 100, 1, 0);
		send_request(MODE_FREE, 0, 56, 1, 0);
		send_request(MODE_FREE, 0, 56, 1, 0);
		send_request(MODE_FREE, 0, 56, 1, 1);
		write_region(21'h1FFFFF);
		send_request(MODE_ALLOC, 1048576 - 24 - 32, 0, 0, 0);
		send_request(MODE_FREE, 0, 56, 1, 1);
		send_request(MODE_ALLOC, 1048576 - 24 - 32 - 32, 0, 0, 0);
		send_request(MODE_ALLOC, 1048576 - 24 - 32 - 40, 0, 0, 0);

		// Back pressure: the receiver holds off while requests keep coming.
		write_region(21'd4096);
		long_hold = 1;
		repeat (30) send_request(MODE_ALLOC, $urandom_range(0, 40), 0, 0, 0);

		// Random phases over several region sizes, small regions favored.
		cfg_vals = '{21'd8192, 21'd4096, 21'd20000, 21'd1048576, 21'd4097, 21'd0};
		foreach (cfg_vals[p]) begin
			write_region(cfg_vals[p]);
			repeat (p == 3 ? 150 : 300) random_request();
		end
		write_region(21'd12288);
		repeat (200) random_request();

		wait_idle();
		$display("Ran %0d requests, checked %0d results over several region sizes.",
			request_count, result_count);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire
